[hw/rtl/pfl_pkg.sv]
// ----------------------------------------------------------------------------
// pfl_pkg: shared types and constants of the per-CPU page free-list allocator
// Sizes, status and operation codes, controller states, command/status bundles.
// ----------------------------------------------------------------------------
package pfl_pkg;

  localparam int NUM_CPUS   = 8;
  localparam int NUM_PAGES  = 32768;
  localparam int PAGE_BYTES = 4096;

  localparam int ADDR_W     = 40;
  localparam int CPU_ID_W   = 3;
  localparam int LIMIT_W    = 10;
  localparam int CPU_W      = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
  localparam int IDX_W      = $clog2(NUM_PAGES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int PG_W       = ADDR_W - PAGE_SHIFT;
  localparam int IN_DATA_W  = ((CPU_ID_W + ADDR_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ADDR_W + 7) / 8) * 8;

  localparam logic [ADDR_W-1:0]  RST_REGION_START = ADDR_W'(64'd2147483648);
  localparam logic [ADDR_W-1:0]  RST_REGION_TOP   = ADDR_W'(64'd2281701376);
  localparam logic [LIMIT_W-1:0] RST_STEAL_LIMIT  = LIMIT_W'(100);

  typedef enum logic {
    FUNC_FREE  = 1'b0,
    FUNC_ALLOC = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OOM     = 2'd1,
    ST_BADFREE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_REGION_START = 2'd0,
    CFG_REGION_TOP   = 2'd1,
    CFG_STEAL_LIMIT  = 2'd2
  } cfg_reg_t;

  // Link word: a valid flag and a page index
  typedef struct packed {
    logic             vld;
    logic [IDX_W-1:0] idx;
  } link_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FCHK,
    S_FPUSH,
    S_ASEL,
    S_POP,
    S_WREQ,
    S_WDAT,
    S_WEND,
    S_WFIX,
    S_WDONE,
    S_RESP
  } state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_FCHK,
    OP_FPUSH,
    OP_ASEL,
    OP_POP,
    OP_WREQ,
    OP_WDAT,
    OP_WEND,
    OP_WNULL,
    OP_WFIX,
    OP_WDONE
  } op_t;

  typedef struct packed {
    op_t  op;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic free_ok;
    logic own_vld;
    logic vict_found;
    logic walk_go;
    logic last_vld;
  } dp_stat_t;

  // Fold a raw CPU id into the range of CPUs
  function automatic logic [CPU_W-1:0] fold_cpu(input logic [CPU_ID_W-1:0] c);
    logic [7:0] r;
    r = 8'(c);
    for (int k = 0; k < (1 << CPU_ID_W); k++) begin
      if (r >= 8'(NUM_CPUS)) begin
        r = r - 8'(NUM_CPUS);
      end
    end
    return r[CPU_W-1:0];
  endfunction

endpackage

[hw/rtl/pfl_ctrl.sv]
// ----------------------------------------------------------------------------
// pfl_ctrl: request sequencer
// Steps one request at a time through free, pop and steal walks; owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module pfl_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_func,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  pfl_pkg::dp_stat_t stat,
  output pfl_pkg::dp_cmd_t  cmd
);

  pfl_pkg::state_t state_r, state_nxt;
  logic            out_vld_r, out_vld_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= pfl_pkg::S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cmd.op       = pfl_pkg::OP_NONE;
    cmd.out_load = 1'b0;
    in_tready    = 1'b0;
    out_vld_nxt  = out_vld_r;
    if (out_vld_r && out_tready) begin
      out_vld_nxt = 1'b0;
    end
    unique case (state_r)
      pfl_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.op    = pfl_pkg::OP_LOAD;
          state_nxt = (in_func == pfl_pkg::FUNC_ALLOC) ? pfl_pkg::S_ASEL : pfl_pkg::S_FCHK;
        end
      end
      pfl_pkg::S_FCHK: begin
        cmd.op    = pfl_pkg::OP_FCHK;
        state_nxt = pfl_pkg::S_FPUSH;
      end
      pfl_pkg::S_FPUSH: begin
        cmd.op    = pfl_pkg::OP_FPUSH;
        state_nxt = pfl_pkg::S_RESP;
      end
      pfl_pkg::S_ASEL: begin
        cmd.op = pfl_pkg::OP_ASEL;
        priority if (stat.own_vld) begin
          state_nxt = pfl_pkg::S_POP;
        end else if (stat.vict_found) begin
          state_nxt = pfl_pkg::S_WREQ;
        end else begin
          state_nxt = pfl_pkg::S_RESP;
        end
      end
      pfl_pkg::S_POP: begin
        cmd.op    = pfl_pkg::OP_POP;
        state_nxt = pfl_pkg::S_RESP;
      end
      pfl_pkg::S_WREQ: begin
        if (stat.walk_go) begin
          cmd.op    = pfl_pkg::OP_WREQ;
          state_nxt = pfl_pkg::S_WDAT;
        end else begin
          state_nxt = pfl_pkg::S_WEND;
        end
      end
      pfl_pkg::S_WDAT: begin
        cmd.op    = pfl_pkg::OP_WDAT;
        state_nxt = pfl_pkg::S_WREQ;
      end
      pfl_pkg::S_WEND: begin
        // A live tail link means the victim keeps the pages behind it
        if (stat.last_vld) begin
          cmd.op    = pfl_pkg::OP_WEND;
          state_nxt = pfl_pkg::S_WFIX;
        end else begin
          cmd.op    = pfl_pkg::OP_WNULL;
          state_nxt = pfl_pkg::S_WDONE;
        end
      end
      pfl_pkg::S_WFIX: begin
        cmd.op    = pfl_pkg::OP_WFIX;
        state_nxt = pfl_pkg::S_WDONE;
      end
      pfl_pkg::S_WDONE: begin
        cmd.op    = pfl_pkg::OP_WDONE;
        state_nxt = pfl_pkg::S_RESP;
      end
      pfl_pkg::S_RESP: begin
        // Hold until the output register is free
        if (!out_vld_r || out_tready) begin
          cmd.out_load = 1'b1;
          out_vld_nxt  = 1'b1;
          state_nxt    = pfl_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pfl_pkg::S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_vld_r;

endmodule

[hw/rtl/pfl_dpath.sv]
// ----------------------------------------------------------------------------
// pfl_dpath: allocator datapath
// Configuration registers, per-CPU list heads, next-link memory, free-address
// checks, steal walk registers and the result/output registers.
// ----------------------------------------------------------------------------
module pfl_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_index,
  input  logic [pfl_pkg::ADDR_W-1:0]      cfg_data,
  input  logic [pfl_pkg::IN_DATA_W-1:0]   in_tdata,
  input  pfl_pkg::dp_cmd_t                cmd,
  output pfl_pkg::dp_stat_t               stat,
  output logic [pfl_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [1:0]                      out_tuser
);

  logic [pfl_pkg::ADDR_W-1:0]  start_r, top_r;
  logic [pfl_pkg::LIMIT_W-1:0] limit_r;
  pfl_pkg::link_t              head_r [pfl_pkg::NUM_CPUS];
  pfl_pkg::link_t              mem [pfl_pkg::NUM_PAGES];
  pfl_pkg::link_t              rdata_r;

  logic [pfl_pkg::CPU_W-1:0]   cpu_r, vict_r, vict_sel;
  logic [pfl_pkg::ADDR_W-1:0]  addr_r;
  logic                        aligned_r, ge_r, lt_r;
  logic [pfl_pkg::PG_W-1:0]    pg_r;
  pfl_pkg::link_t              first_r, last_r, link_first_r;
  logic [pfl_pkg::LIMIT_W-1:0] steps_r;
  logic [pfl_pkg::ADDR_W-1:0]  res_addr_r, out_addr_r;
  pfl_pkg::status_t            res_st_r, out_st_r;

  logic                        free_ok, vict_found;
  pfl_pkg::link_t              own;
  logic [pfl_pkg::ADDR_W-1:0]  diff, page_addr;
  logic                        mem_we;
  logic [pfl_pkg::IDX_W-1:0]   mem_waddr, mem_raddr;
  pfl_pkg::link_t              mem_wdata;

  assign own       = head_r[cpu_r];
  assign diff      = addr_r - start_r;
  assign free_ok   = aligned_r && ge_r && lt_r &&
                     (pg_r < pfl_pkg::PG_W'(pfl_pkg::NUM_PAGES));
  assign page_addr = start_r + (pfl_pkg::ADDR_W'(first_r.idx) << pfl_pkg::PAGE_SHIFT);

  // Lowest-numbered other CPU with a non-empty list
  always_comb begin
    vict_found = 1'b0;
    vict_sel   = '0;
    for (int v = pfl_pkg::NUM_CPUS - 1; v >= 0; v--) begin
      if ((pfl_pkg::CPU_W'(v) != cpu_r) && head_r[v].vld) begin
        vict_found = 1'b1;
        vict_sel   = pfl_pkg::CPU_W'(v);
      end
    end
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = last_r.idx;
    mem_wdata = '0;
    mem_raddr = last_r.idx;
    unique case (cmd.op)
      pfl_pkg::OP_FPUSH: begin
        mem_we    = free_ok;
        mem_waddr = pg_r[pfl_pkg::IDX_W-1:0];
        mem_wdata = own;
      end
      pfl_pkg::OP_ASEL: begin
        mem_raddr = own.idx;
      end
      pfl_pkg::OP_WFIX: begin
        // Cut the stolen run off at its tail
        mem_we = 1'b1;
      end
      default: begin
        mem_raddr = last_r.idx;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= pfl_pkg::RST_REGION_START;
      top_r   <= pfl_pkg::RST_REGION_TOP;
      limit_r <= pfl_pkg::RST_STEAL_LIMIT;
      for (int c = 0; c < pfl_pkg::NUM_CPUS; c++) begin
        head_r[c] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          pfl_pkg::CFG_REGION_START: start_r <= cfg_data;
          pfl_pkg::CFG_REGION_TOP:   top_r   <= cfg_data;
          pfl_pkg::CFG_STEAL_LIMIT:  limit_r <= cfg_data[pfl_pkg::LIMIT_W-1:0];
          default: ;
        endcase
      end
      unique case (cmd.op)
        pfl_pkg::OP_FPUSH: begin
          if (free_ok) begin
            head_r[cpu_r] <= '{vld: 1'b1, idx: pg_r[pfl_pkg::IDX_W-1:0]};
          end
        end
        pfl_pkg::OP_POP:   head_r[cpu_r]  <= rdata_r;
        pfl_pkg::OP_WNULL: head_r[vict_r] <= '0;
        pfl_pkg::OP_WFIX:  head_r[vict_r] <= rdata_r;
        pfl_pkg::OP_WDONE: begin
          // The tail was cleared; if it is the first page, nothing remains
          if (last_r.vld && (last_r.idx == first_r.idx)) begin
            head_r[cpu_r] <= '0;
          end else begin
            head_r[cpu_r] <= link_first_r;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      pfl_pkg::OP_LOAD: begin
        cpu_r  <= pfl_pkg::fold_cpu(in_tdata[pfl_pkg::CPU_ID_W-1:0]);
        addr_r <= in_tdata[pfl_pkg::CPU_ID_W +: pfl_pkg::ADDR_W];
      end
      pfl_pkg::OP_FCHK: begin
        aligned_r <= (addr_r[pfl_pkg::PAGE_SHIFT-1:0] == '0);
        ge_r      <= (addr_r >= start_r);
        lt_r      <= (addr_r < top_r);
        pg_r      <= diff[pfl_pkg::ADDR_W-1:pfl_pkg::PAGE_SHIFT];
      end
      pfl_pkg::OP_FPUSH: begin
        res_addr_r <= '0;
        res_st_r   <= free_ok ? pfl_pkg::ST_OK : pfl_pkg::ST_BADFREE;
      end
      pfl_pkg::OP_ASEL: begin
        priority if (own.vld) begin
          first_r <= own;
        end else if (vict_found) begin
          vict_r  <= vict_sel;
          first_r <= head_r[vict_sel];
          last_r  <= head_r[vict_sel];
          steps_r <= '0;
        end else begin
          res_addr_r <= '0;
          res_st_r   <= pfl_pkg::ST_OOM;
        end
      end
      pfl_pkg::OP_POP, pfl_pkg::OP_WDONE: begin
        res_addr_r <= page_addr;
        res_st_r   <= pfl_pkg::ST_OK;
      end
      pfl_pkg::OP_WDAT: begin
        last_r  <= rdata_r;
        steps_r <= steps_r + 1'b1;
        if (steps_r == '0) begin
          link_first_r <= rdata_r;
        end
      end
      default: ;
    endcase
    if (cmd.out_load) begin
      out_addr_r <= res_addr_r;
      out_st_r   <= res_st_r;
    end
  end

  assign stat.free_ok    = free_ok;
  assign stat.own_vld    = own.vld;
  assign stat.vict_found = vict_found;
  assign stat.walk_go    = last_r.vld && (steps_r < limit_r);
  assign stat.last_vld   = last_r.vld;

  assign out_tdata = pfl_pkg::OUT_DATA_W'(out_addr_r);
  assign out_tuser = out_st_r;

endmodule

[hw/rtl/percpu_page_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// percpu_page_free_list_allocator: per-CPU free lists of pages with stealing
// Free pushes a page on the caller's list, allocate pops it or steals a run
// of pages from the first other CPU with a non-empty list.
// ----------------------------------------------------------------------------
// One item at a time: a new item is taken only after the result of the last
// one has entered the output register. The steal walk alternates a request
// and a data state for each link it reads from the link memory. Reset
// empties all lists and loads the register defaults; the link memory is not
// cleared.
module percpu_page_free_list_allocator (
  input  logic                            clk,
  input  logic                            rst_n,
  // config write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [pfl_pkg::ADDR_W-1:0]      cfg_data,
  // request channel
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [pfl_pkg::IN_DATA_W-1:0]   in_tdata,   // [2:0] cpu_id, [42:3] page_address
  input  logic [0:0]                      in_tuser,   // [0] func
  // result channel
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [pfl_pkg::OUT_DATA_W-1:0]  out_tdata,  // [39:0] alloc_address
  output logic [1:0]                      out_tuser   // [1:0] status
);

  pfl_pkg::dp_cmd_t  cmd;
  pfl_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  pfl_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser[0]),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  pfl_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_tdata  (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while one is in work");

  a_addr_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata != '0) |-> (out_tuser == pfl_pkg::ST_OK))
    else $error("nonzero address with a failure status");

  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(!in_tready))
    else $error("result appeared without an item in work");

endmodule
